// ----- src/radix_integer_text_parser_core_assert.svh -----
// assertion macros for the radix integer text parser core
// included by the modules that carry concurrent checks; no other dependencies
`ifndef RADIX_INTEGER_TEXT_PARSER_CORE_ASSERT_SVH
`define RADIX_INTEGER_TEXT_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RITP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ritp check failed");
// condition must never be seen at a clock edge outside reset
`define RITP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ritp forbidden condition seen");
`else
`define RITP_ASSERT(lbl, clk, rstn, prop)
`define RITP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- src/ritp_pkg.sv -----
// shared types and constants of the radix integer text parser
// used by ritp_front, ritp_queue, ritp_back and the core top level
package ritp_pkg;

  localparam int unsigned MaxFieldLenDef = 65536;
  localparam int unsigned QueueDepth     = 2;

  localparam int unsigned CharW   = 8;
  localparam int unsigned BaseW   = 6;
  localparam int unsigned DigitW  = 6;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned OffsetW = 17;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 56;

  localparam logic [BaseW-1:0] BaseReset = 6'd10;

  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChTab   = 8'h09;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowZ  = 8'h7A;
  localparam logic [CharW-1:0] LetterBias = 8'd10;

  typedef enum logic [1:0] {
    PH_SPACE   = 2'd0,
    PH_DIGITS  = 2'd1,
    PH_STOPPED = 2'd2
  } ritp_phase_e;

  // one classified character
  typedef struct packed {
    logic              is_space;
    logic              is_sign;
    logic              is_minus;
    logic              is_alnum;
    logic [DigitW-1:0] dval;
    logic              last;
  } ritp_item_t;

endpackage

// ----- src/ritp_front.sv -----
// front end: accepts characters and classifies them for the scan back end
// depends on ritp_pkg
module ritp_front import ritp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  logic [CharW-1:0]   s_char_i,
  input  logic               s_last_i,
  output logic               enq_valid_o,
  input  logic               enq_ready_i,
  output ritp_item_t         enq_item_o
);

  logic             is_num, is_up, is_low;
  logic [CharW-1:0] dval_full;

  always_comb begin
    is_num = (s_char_i >= ChZero) && (s_char_i <= ChNine);
    is_up  = (s_char_i >= ChUpA)  && (s_char_i <= ChUpZ);
    is_low = (s_char_i >= ChLowA) && (s_char_i <= ChLowZ);
    priority if (is_num) begin
      dval_full = s_char_i - ChZero;
    end else if (is_up) begin
      dval_full = s_char_i - ChUpA + LetterBias;
    end else begin
      dval_full = s_char_i - ChLowA + LetterBias;
    end
    enq_item_o.is_space = (s_char_i == ChSpace) || (s_char_i == ChTab);
    enq_item_o.is_sign  = (s_char_i == ChPlus) || (s_char_i == ChMinus);
    enq_item_o.is_minus = (s_char_i == ChMinus);
    enq_item_o.is_alnum = is_num || is_up || is_low;
    enq_item_o.dval     = dval_full[DigitW-1:0];
    enq_item_o.last     = s_last_i;
  end

  assign enq_valid_o = s_valid_i;
  assign s_ready_o   = enq_ready_i;

  `include "radix_integer_text_parser_core_assert.svh"

  // a classified digit always carries a value below 36
  `RITP_ASSERT(a_dval_range, clk_i, rst_ni,
    !(s_valid_i && enq_item_o.is_alnum) || (enq_item_o.dval < DigitW'(36)))

endmodule

// ----- src/ritp_queue.sv -----
// short queue of classified characters between front and back end
// depends on ritp_pkg
module ritp_queue import ritp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ritp_item_t in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ritp_item_t out_item_o
);

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  ritp_item_t         slot_q [QueueDepth];
  logic [AddrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               push, pop;

  assign in_ready_o  = (cnt_q != CntW'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = slot_q[rd_ptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

  `include "radix_integer_text_parser_core_assert.svh"

  `RITP_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(QueueDepth))
  `RITP_ASSERT(a_cnt_grow, clk_i, rst_ni,
    (push && !pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))

endmodule

// ----- src/ritp_back.sv -----
// back end: scan state, radix multiply-add, offset tracking and result register
// depends on ritp_pkg
module ritp_back import ritp_pkg::*; #(
  parameter int unsigned MaxFieldLen = MaxFieldLenDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BaseW-1:0]   base_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  ritp_item_t         item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ValueW-1:0]  out_value_o,
  output logic [OffsetW-1:0] out_offset_o,
  output logic               out_found_o
);

  localparam int unsigned CntBits = $clog2(MaxFieldLen + 1);
  localparam int unsigned PosW    = (CntBits > OffsetW) ? CntBits : OffsetW;

  ritp_phase_e       phase_q, phase_d;
  logic              neg_q, neg_d, any_q, any_d;
  logic [ValueW-1:0] acc_q, acc_d, prod, signed_val;
  logic [PosW-1:0]   pos_q, pos_d, stop_q, stop_d, off_full;
  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q;
  logic [OffsetW-1:0] out_offset_q;
  logic              out_found_q;
  logic              out_free, take, digit_phase, is_digit;

  assign out_free     = !out_valid_q || out_ready_i;
  assign item_ready_o = !item_i.last || out_free;
  assign take         = item_valid_i && item_ready_o;
  assign is_digit     = item_i.is_alnum && (item_i.dval < base_i);
  assign prod         = acc_q * {{(ValueW-BaseW){1'b0}}, base_i};

  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    any_d       = any_q;
    acc_d       = acc_q;
    stop_d      = stop_q;
    pos_d       = pos_q;
    digit_phase = 1'b0;
    unique case (phase_q)
      PH_SPACE: begin
        if (item_i.is_sign) begin
          neg_d   = item_i.is_minus;
          phase_d = PH_DIGITS;
        end else if (!item_i.is_space) begin
          digit_phase = 1'b1;
        end
      end
      PH_DIGITS:  digit_phase = 1'b1;
      PH_STOPPED: digit_phase = 1'b0;
      default:    digit_phase = 1'b0;
    endcase
    if (digit_phase) begin
      if (is_digit) begin
        acc_d   = prod + {{(ValueW-DigitW){1'b0}}, item_i.dval};
        any_d   = 1'b1;
        phase_d = PH_DIGITS;
      end else begin
        phase_d = PH_STOPPED;
        stop_d  = pos_q;
      end
    end
    if (pos_q != PosW'(MaxFieldLen)) begin
      pos_d = pos_q + PosW'(1);
    end
    signed_val = neg_d ? (ValueW'(0) - acc_d) : acc_d;
    off_full   = (phase_d == PH_STOPPED) ? stop_d : pos_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take && item_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACE;
      neg_q       <= 1'b0;
      any_q       <= 1'b0;
      acc_q       <= '0;
      pos_q       <= '0;
      stop_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        if (item_i.last) begin
          phase_q <= PH_SPACE;
          neg_q   <= 1'b0;
          any_q   <= 1'b0;
          acc_q   <= '0;
          pos_q   <= '0;
          stop_q  <= '0;
        end else begin
          phase_q <= phase_d;
          neg_q   <= neg_d;
          any_q   <= any_d;
          acc_q   <= acc_d;
          pos_q   <= pos_d;
          stop_q  <= stop_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && item_i.last) begin
      out_value_q  <= any_d ? signed_val : '0;
      out_offset_q <= off_full[OffsetW-1:0];
      out_found_q  <= any_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_offset_o = out_offset_q;
  assign out_found_o  = out_found_q;

  `include "radix_integer_text_parser_core_assert.svh"

  `RITP_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    take && item_i.last && out_valid_q && !out_ready_i)
  `RITP_ASSERT(a_clear_after_last, clk_i, rst_ni,
    (take && item_i.last) |=> (phase_q == PH_SPACE && pos_q == '0 && !any_q))
  `RITP_ASSERT(a_acc_without_digit, clk_i, rst_ni, any_q || (acc_q == '0))
  `RITP_ASSERT(a_stop_not_ahead, clk_i, rst_ni,
    (phase_q != PH_STOPPED) || (stop_q <= pos_q))

endmodule

// ----- src/radix_integer_text_parser_core.sv -----
// top level of the radix integer text parser: channels, radix register, wiring
// depends on ritp_pkg, ritp_front, ritp_queue and ritp_back
//
// usage
// - input stream: one character per transaction in s_axis_tdata[7:0], s_axis_tlast
//   set on the final character of a field; leading spaces and tabs are skipped,
//   one sign is taken, then digits of the radix are accumulated modulo 2^32
// - output stream: one transaction per field, issued for its last character
// - config channel: cfg_data_i holds the radix (reset value 10); write it only
//   while no field is in flight; cfg_ready_o is always high
// - throughput: one character per cycle, sustained, fields back to back, while results are
//   taken; the radix multiply-add in ritp_back takes one character each cycle
// - result path: the last character is queued at the accepting edge and the result is
//   registered by the back end once it leaves the queue and the result register is free
// - stall: when m_axis_tready is low the result register holds; characters keep
//   flowing until the next last character, which waits at the head of the
//   two-entry queue; once one more character is queued s_axis_tready drops
// - reset: asynchronous, active low; clears scan state, queue and result valid,
//   and sets the radix back to 10
module radix_integer_text_parser_core import ritp_pkg::*; #(
  parameter int unsigned MaxFieldLen = MaxFieldLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input characters
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // [7:0] char_code
  input  logic                s_axis_tlast,  // last_char
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // [31:0] parsed_value, [48:32] stop_offset,
                                             // [49] digits_found, [55:50] zero
  // radix register write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [BaseW-1:0]    cfg_data_i
);

  logic [BaseW-1:0] base_q;

  // classified characters between front and queue, queue and back end
  logic       enq_valid, enq_ready, deq_valid, deq_ready;
  ritp_item_t enq_item, deq_item;

  logic [ValueW-1:0]  res_value;
  logic [OffsetW-1:0] res_offset;
  logic               res_found;

  // radix register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  ritp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_char_i    (s_axis_tdata[CharW-1:0]),
    .s_last_i    (s_axis_tlast),
    .enq_valid_o (enq_valid),
    .enq_ready_i (enq_ready),
    .enq_item_o  (enq_item)
  );

  ritp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (enq_valid),
    .in_ready_o  (enq_ready),
    .in_item_i   (enq_item),
    .out_valid_o (deq_valid),
    .out_ready_i (deq_ready),
    .out_item_o  (deq_item)
  );

  ritp_back #(
    .MaxFieldLen (MaxFieldLen)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_i       (base_q),
    .item_valid_i (deq_valid),
    .item_ready_o (deq_ready),
    .item_i       (deq_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (res_value),
    .out_offset_o (res_offset),
    .out_found_o  (res_found)
  );

  // pack result fields, lowest field first, zero fill to whole bytes
  assign m_axis_tdata = {{(OutDataW-ValueW-OffsetW-1){1'b0}}, res_found, res_offset,
                         res_value};

endmodule

// ----- tb/radix_integer_text_parser_core_test.sv -----
// self-checking testbench for radix_integer_text_parser_core: characters in, results out
// predicts each field's value, stop offset and digit flag from the accepted characters
// depends on ritp_pkg and the core top level only
`timescale 1ns / 1ps

module radix_integer_text_parser_core_test;
  import ritp_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleDelay = 4;
  localparam int unsigned RandomTarget = 620;
  localparam logic [7:0]  NotADigit   = 8'd255;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    logic [ValueW-1:0]  value;
    logic [OffsetW-1:0] offset;
    logic               found;
  } parse_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [BaseW-1:0]    cfg_data_i;

  // scan state mirrored from the accepted transactions
  ritp_phase_e        scan_phase = PH_SPACE;
  logic               neg_sign   = 1'b0;
  logic [ValueW-1:0]  acc_value  = '0;
  logic               saw_digit  = 1'b0;
  logic [OffsetW-1:0] char_pos   = '0;
  logic [OffsetW-1:0] stop_pos   = '0;
  logic [BaseW-1:0]   radix      = BaseReset;

  parse_result_t expected_parses[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   random_chars   = 0;

  // traffic shaping knobs
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;
  bit hold_request = 1'b0;

  radix_integer_text_parser_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
    .s_axis_tlast  (s_axis_tlast),   // last_char
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [31:0] parsed_value, [48:32] stop_offset,
                                     // [49] digits_found, [55:50] zero
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // digit weight of a character, case-insensitive letters count from ten
  function automatic logic [7:0] digit_of(input logic [7:0] ch);
    if (ch >= ChZero && ch <= ChNine) return ch - ChZero;
    if (ch >= ChUpA && ch <= ChUpZ) return ch - ChUpA + LetterBias;
    if (ch >= ChLowA && ch <= ChLowZ) return ch - ChLowA + LetterBias;
    return NotADigit;
  endfunction

  task automatic clear_scan();
    scan_phase = PH_SPACE;
    neg_sign   = 1'b0;
    acc_value  = '0;
    saw_digit  = 1'b0;
    char_pos   = '0;
    stop_pos   = '0;
  endtask

  // advance the scan by one character; a last character yields one result
  task automatic scan_char(input logic [7:0] ch, input logic lst);
    logic [OffsetW-1:0] here;
    logic               examine;
    logic [7:0]         dv;
    parse_result_t      res;
    here    = char_pos;
    examine = 1'b1;
    if (scan_phase == PH_SPACE) begin
      if (ch == ChSpace || ch == ChTab) begin
        examine = 1'b0;
      end else if (ch == ChPlus || ch == ChMinus) begin
        // the sign is consumed here, digits start with the next character
        neg_sign   = (ch == ChMinus);
        scan_phase = PH_DIGITS;
        examine    = 1'b0;
      end else begin
        scan_phase = PH_DIGITS;
      end
    end
    if (scan_phase == PH_DIGITS && examine) begin
      dv = digit_of(ch);
      if (dv < {2'b00, radix}) begin
        acc_value = acc_value * ValueW'(radix) + ValueW'(dv);
        saw_digit = 1'b1;
      end else begin
        scan_phase = PH_STOPPED;
        stop_pos   = here;
      end
    end
    // position saturates for overlong fields
    if (char_pos < OffsetW'(MaxFieldLenDef)) char_pos++;
    if (lst) begin
      res.offset = (scan_phase == PH_STOPPED) ? stop_pos : char_pos;
      res.value  = neg_sign ? -acc_value : acc_value;
      if (!saw_digit) res.value = '0;
      res.found  = saw_digit;
      expected_parses.push_back(res);
      clear_scan();
    end
  endtask

  // watch accepted config and character transactions
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_scan();
      radix = BaseReset;
    end else begin
      if (cfg_valid_i && cfg_ready_o) radix = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) scan_char(s_axis_tdata, s_axis_tlast);
    end
  end

  // compare every result transaction with the oldest prediction
  always @(posedge clk_i) begin
    parse_result_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_parses.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        exp_res = expected_parses.pop_front();
        if (m_axis_tdata[ValueW-1:0] !== exp_res.value) begin
          $display("%0t: parsed_value expected %0d actual %0d", $time,
                   $signed(exp_res.value), $signed(m_axis_tdata[ValueW-1:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[ValueW+OffsetW-1:ValueW] !== exp_res.offset) begin
          $display("%0t: stop_offset expected %0d actual %0d", $time,
                   exp_res.offset, m_axis_tdata[ValueW+OffsetW-1:ValueW]);
          mismatch_count++;
        end
        if (m_axis_tdata[ValueW+OffsetW] !== exp_res.found) begin
          $display("%0t: digits_found expected %0b actual %0b", $time,
                   exp_res.found, m_axis_tdata[ValueW+OffsetW]);
          mismatch_count++;
        end
        if (m_axis_tdata[OutDataW-1:ValueW+OffsetW+1] !== '0) begin
          $display("%0t: pad bits expected 0 actual %h", $time,
                   m_axis_tdata[OutDataW-1:ValueW+OffsetW+1]);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random ready, steady stretches, and one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned run_len;
    int unsigned held;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        @(negedge clk_i) m_axis_tready <= 1'b0;
        hold_request = 1'b0;
        for (held = 1; held < HoldCycles; held++) @(negedge clk_i);
      end else if (rx_steady) begin
        @(negedge clk_i) m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        run_len = $urandom_range(1, 12);
        @(negedge clk_i) m_axis_tready <= 1'b1;
        repeat (run_len - 1) @(negedge clk_i);
      end else begin
        // mostly short stalls, now and then a long one
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        @(negedge clk_i) m_axis_tready <= 1'b0;
        repeat (run_len - 1) @(negedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one character and hold it until the transaction completes
  task automatic send_char(input logic [7:0] ch, input logic lst);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_field(input char_q_t chars);
    int i;
    for (i = 0; i < chars.size(); i++) send_char(chars[i], i == chars.size() - 1);
  endtask

  task automatic send_text(input string text);
    char_q_t chars;
    int i;
    for (i = 0; i < text.len(); i++) chars.push_back(text[i]);
    send_field(chars);
  endtask

  // let every pending result drain, then the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    while (expected_parses.size() != 0) @(posedge clk_i);
    repeat (SettleDelay) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [BaseW-1:0] base);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned d);
    if (d < 10) return ChZero + 8'(d);
    return ($urandom_range(0, 1) ? ChUpA : ChLowA) + 8'(d - 10);
  endfunction

  // character from the interesting classes, or any byte at all
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return ChSpace;
      1: return ChTab;
      2: return ChPlus;
      3: return ChMinus;
      4: return digit_char($urandom_range(0, 35));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed numbers in the current radix, the rest noise
  function automatic char_q_t build_field(input logic [BaseW-1:0] base);
    char_q_t     chars;
    int unsigned usable;
    int unsigned n;
    int unsigned i;
    usable = (base > 36) ? 36 : base;
    if (usable == 0 || $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) chars.push_back(noise_char());
      return chars;
    end
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) chars.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
    case ($urandom_range(0, 2))
      1: chars.push_back(ChPlus);
      2: chars.push_back(ChMinus);
      default: ;
    endcase
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 8);
    for (i = 0; i < n; i++) chars.push_back(digit_char($urandom_range(0, usable - 1)));
    if ($urandom_range(0, 1)) begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) chars.push_back(8'($urandom_range(0, 255)));
    end
    return chars;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // decimal after reset: signs, whitespace, wrap, stop and no-digit cases
  task automatic test_reset_radix();
    send_text("123");
    send_text(" \t-42");
    send_text("2147483648");     // wraps into the negative range
    send_text("99999999999");    // overflow without a flag
    send_text("12a4");           // stops at the letter
    send_text("  ");             // whitespace only
    send_text("-");              // sign only
    send_text("+-5");            // second sign ends the scan
    send_text("xyz");            // no digit at all
    wait_idle();
  endtask

  // radix register at its extremes, including the out-of-range codes
  task automatic test_radix_extremes();
    write_radix(6'd2);
    send_text("-1011");
    send_text("1021");
    write_radix(6'd36);
    send_text("zZ9");
    send_text("-ZzZzZzZ");
    write_radix(6'd0);           // accepts no digit
    send_text("5");
    write_radix(6'd1);           // accepts only zero
    send_text("001");
    write_radix(6'd63);          // every letter accepted, weighed by 63
    send_text("zZ!");
    wait_idle();
  endtask

  // sink holds off for a long stretch while fields keep coming
  task automatic test_output_stall();
    int unsigned i;
    hold_request = 1'b1;
    tx_steady    = 1'b1;
    // start sending once the sink has begun its hold
    wait (hold_request == 1'b0);
    for (i = 0; i < 12; i++) send_field(build_field(radix));
    tx_steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_fields();
    int unsigned nfields;
    int unsigned i;
    char_q_t     chars;
    logic [BaseW-1:0] base;
    while (random_chars < RandomTarget) begin
      case ($urandom_range(0, 9))
        0: base = BaseW'($urandom_range(0, 1));
        1: base = BaseW'($urandom_range(37, 63));
        default: base = BaseW'($urandom_range(2, 36));
      endcase
      write_radix(base);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      nfields = $urandom_range(10, 25);
      for (i = 0; i < nfields; i++) begin
        chars = build_field(base);
        random_chars += chars.size();
        send_field(chars);
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    test_reset_radix();
    test_radix_extremes();
    test_output_stall();
    test_random_fields();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
